>>> hdl/vdi_pkg.sv
// package for the vertex dedup indexer: sizes, register indexes and payload types
package vdi_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int COORD_BITS    = 24;
  localparam int NCOMP         = 8;
  localparam int IDX_BITS      = 10;
  localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS      = $clog2(TABLE_DEPTH + 1);
  localparam int TOL_BITS      = 23;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 23;
  localparam int CMP_BITS      = (COORD_BITS + 1 > TOL_BITS) ? COORD_BITS + 1 : TOL_BITS;

  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(655);

  localparam logic [CFG_IDX_BITS-1:0] CFG_EXACT_MODE = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_MATCH_TOL  = CFG_IDX_BITS'(1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one stored table row: all eight components side by side
  typedef logic [NCOMP-1:0][COORD_BITS-1:0] entry_t;

  typedef struct packed {
    logic   start_mesh;
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t tex_u;
    coord_t tex_v;
    coord_t norm_x;
    coord_t norm_y;
    coord_t norm_z;
  } vertex_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] vertex_index;
    logic                is_new;
    logic                table_overflow;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

endpackage

>>> hdl/vertex_dedup_indexer.sv
// vertex dedup indexer: linear search of the unique vertex table held in one ram
//
// Usage: a vertex enters on the vtx channel (vtx_valid/vtx_stall), one result
// leaves on the res channel (res_valid/res_stall) for every vertex. A vertex
// with start_mesh set empties the table before it is looked up. The cfg port
// (cfg_valid/cfg_ready, always ready) writes exact_mode at index 0 and
// match_tolerance at index 1; other indexes are dropped. Write it only when
// no vertex is in flight.
// Timing: the table ram is read one row per cycle from entry 0 up, with the
// compare on the row read in the cycle before. A search that hits ends at
// the first matching row; one that misses reads every row below the count.
// One vertex is worked on at a time; the next one is taken as soon as the
// result sits in the output register, even while res_stall holds it there.
// Reset: clears the count (empty table), restores exact_mode 0 and tolerance
// 655. The ram needs no clearing pass, only rows below the count are read.
// A stalled result holds the output register; the block then finishes at
// most one more vertex and waits with vtx_stall high.
module vertex_dedup_indexer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           vtx_valid,
  output logic                           vtx_stall,
  input  vdi_pkg::vertex_t               vtx,
  output logic                           res_valid,
  input  logic                           res_stall,
  output vdi_pkg::result_t               res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vdi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [vdi_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import vdi_pkg::*;

  state_t               state;
  logic                 exact_mode;
  logic [TOL_BITS-1:0]  match_tolerance;
  logic [CNT_BITS-1:0]  unique_count;
  logic [CNT_BITS-1:0]  rd_ptr;
  logic [ADDR_BITS-1:0] cmp_idx;
  logic                 cmp_live;
  entry_t               cur;
  entry_t               rd_data;
  result_t              pending;
  entry_t               table_mem [TABLE_DEPTH];

  logic                 vtx_xfer;
  logic                 out_free;
  logic                 hit;
  logic                 issue;
  logic                 miss_done;
  logic                 append;
  logic                 full;
  logic [NCOMP-1:0]     comp_ok;

  assign cfg_ready = 1'b1;
  assign vtx_stall = (state != ST_IDLE);
  assign vtx_xfer  = vtx_valid && !vtx_stall;
  assign out_free  = !res_valid || !res_stall;
  assign full      = (unique_count >= CNT_BITS'(TABLE_DEPTH));
  assign issue     = (state == ST_SEARCH) && (rd_ptr < unique_count);
  assign hit       = (state == ST_SEARCH) && cmp_live && (&comp_ok);
  assign miss_done = (state == ST_SEARCH) && !hit && !issue;
  assign append    = miss_done && !full;

  // per component compare against the row read last cycle
  always_comb begin
    logic signed [COORD_BITS:0] diff;
    logic        [COORD_BITS:0] mag;
    for (int k = 0; k < NCOMP; k++) begin
      diff = $signed({cur[k][COORD_BITS-1], cur[k]})
           - $signed({rd_data[k][COORD_BITS-1], rd_data[k]});
      mag  = diff[COORD_BITS] ? (COORD_BITS+1)'(0) - diff : diff;
      if (exact_mode) begin
        comp_ok[k] = (diff == '0);
      end else begin
        comp_ok[k] = (CMP_BITS'(mag) < CMP_BITS'(match_tolerance));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exact_mode      <= 1'b0;
      match_tolerance <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EXACT_MODE: exact_mode      <= cfg_data[0];
        CFG_MATCH_TOL:  match_tolerance <= cfg_data[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      unique_count <= '0;
      rd_ptr       <= '0;
      cmp_live     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (vtx_xfer) begin
            if (vtx.start_mesh) begin
              unique_count <= '0;
            end
            rd_ptr   <= '0;
            cmp_live <= 1'b0;
            state    <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (issue) begin
            rd_ptr <= rd_ptr + CNT_BITS'(1);
          end
          cmp_live <= issue;
          if (append) begin
            unique_count <= unique_count + CNT_BITS'(1);
          end
          if (hit || miss_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload side: vertex latch, ram, compare index, pending result
  always_ff @(posedge clk) begin
    if (vtx_xfer) begin
      cur <= {vtx.pos_x, vtx.pos_y, vtx.pos_z, vtx.tex_u,
              vtx.tex_v, vtx.norm_x, vtx.norm_y, vtx.norm_z};
    end
    if (issue) begin
      rd_data <= table_mem[rd_ptr[ADDR_BITS-1:0]];
      cmp_idx <= rd_ptr[ADDR_BITS-1:0];
    end
    if (append) begin
      table_mem[unique_count[ADDR_BITS-1:0]] <= cur;
    end
    if (hit) begin
      pending.vertex_index   <= IDX_BITS'(cmp_idx);
      pending.is_new         <= 1'b0;
      pending.table_overflow <= 1'b0;
    end else if (miss_done) begin
      pending.vertex_index   <= full ? '0 : IDX_BITS'(unique_count);
      pending.is_new         <= !full;
      pending.table_overflow <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      res <= pending;
    end
  end

`ifndef SYNTHESIS
  a_ovf_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.table_overflow) |-> (!res.is_new && res.vertex_index == '0))
    else $error("overflow result carries an index or new flag");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (rd_ptr <= unique_count))
    else $error("read pointer ran past the table count");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    append |=> (unique_count == $past(unique_count) + CNT_BITS'(1)))
    else $error("append did not advance the table count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    append |-> (unique_count < CNT_BITS'(TABLE_DEPTH)))
    else $error("append into a full table");
`endif

endmodule

>>> bench/vertex_dedup_indexer_test.sv
// self-checking testbench for the vertex dedup indexer: directed and random mesh runs
`timescale 1ns / 100ps

module vertex_dedup_indexer_test;
  import vdi_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = CFG_IDX_BITS'(3);
  localparam coord_t C_MAX = 24'h7FFFFF;
  localparam coord_t C_MIN = 24'h800000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vtx_valid = 1'b0;
  logic vtx_stall;
  vertex_t vtx = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  result_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // predictor state: register copies and the unique vertex table
  logic exact_cfg = 1'b0;
  logic [TOL_BITS-1:0] tol_cfg = TOL_RESET;
  int known_count = 0;
  vertex_t known_rows[TABLE_DEPTH];

  vertex_t vtx_pend_q[$];
  result_t index_due_q[$];
  vertex_t mesh_q[$];
  int sent_cnt = 0;
  int taken_cnt = 0;
  int idle_pct = 37;
  int mismatch_cnt = 0;

  vertex_dedup_indexer u_top (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .vtx       (vtx),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic queue_vertex(vertex_t v);
    vtx_pend_q.insert(vtx_pend_q.size(), v);
  endtask

  function automatic coord_t comp_of(vertex_t v, int k);
    return v[(NCOMP-1-k)*COORD_BITS +: COORD_BITS];
  endfunction

  function automatic vertex_t put_comp(vertex_t v, int k, coord_t c);
    vertex_t r;
    r = v;
    r[(NCOMP-1-k)*COORD_BITS +: COORD_BITS] = c;
    return r;
  endfunction

  function automatic vertex_t flat_vertex(logic start, coord_t c);
    vertex_t v;
    int k;
    v = '0;
    v.start_mesh = start;
    for (k = 0; k < NCOMP; k++) v = put_comp(v, k, c);
    return v;
  endfunction

  function automatic vertex_t random_vertex(logic start);
    vertex_t v;
    int k;
    v = '0;
    v.start_mesh = start;
    for (k = 0; k < NCOMP; k++) begin
      if ($urandom_range(3) == 0)
        v = put_comp(v, k, coord_t'(int'($urandom_range(2000)) - 1000));
      else
        v = put_comp(v, k, coord_t'($urandom()));
    end
    return v;
  endfunction

  // move every component by up to span either way
  function automatic vertex_t nudged(vertex_t v, int span);
    vertex_t r;
    int k;
    r = v;
    r.start_mesh = 1'b0;
    for (k = 0; k < NCOMP; k++)
      r = put_comp(r, k, coord_t'(int'(comp_of(v, k)) +
                                  int'($urandom_range(2 * span)) - span));
    return r;
  endfunction

  function automatic bit rows_match(vertex_t a, vertex_t b);
    longint d;
    int k;
    for (k = 0; k < NCOMP; k++) begin
      d = longint'(comp_of(a, k)) - longint'(comp_of(b, k));
      if (exact_cfg) begin
        if (d != 0) return 1'b0;
      end else begin
        if (d < 0) d = -d;
        if (d >= longint'(tol_cfg)) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // first matching row wins, otherwise append unless the table is full
  function automatic result_t lookup_vertex(vertex_t v);
    result_t r;
    int e;
    int hit;
    r = '0;
    hit = -1;
    if (v.start_mesh) known_count = 0;
    for (e = 0; e < known_count && hit < 0; e++)
      if (rows_match(v, known_rows[e])) hit = e;
    if (hit >= 0) begin
      r.vertex_index = IDX_BITS'(hit);
    end else if (known_count >= TABLE_DEPTH) begin
      r.table_overflow = 1'b1;
    end else begin
      known_rows[known_count] = v;
      r.vertex_index = IDX_BITS'(known_count);
      r.is_new = 1'b1;
      known_count++;
    end
    return r;
  endfunction

  task automatic wait_idle();
    while (vtx_pend_q.size() != 0 || sent_cnt != taken_cnt || index_due_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unique case (idx)
      CFG_EXACT_MODE: exact_cfg = data[0];
      CFG_MATCH_TOL:  tol_cfg = data[TOL_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // meshes with repeats and near repeats of earlier vertices, plus stray noise
  task automatic send_mesh_run(int count, int span);
    vertex_t v;
    int i;
    int roll;
    int pick;
    mesh_q.delete();
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      pick = (mesh_q.size() != 0) ? $urandom_range(mesh_q.size() - 1) : 0;
      if (i == 0 || roll < 4) begin
        v = random_vertex(1'b1);
        mesh_q.delete();
      end else if (roll < 44 && mesh_q.size() != 0) begin
        v = mesh_q[pick];
        v.start_mesh = 1'b0;
      end else if (roll < 66 && mesh_q.size() != 0) begin
        v = nudged(mesh_q[pick], span);
      end else if (roll < 70) begin
        v = random_vertex(1'($urandom_range(1)));
        if (v.start_mesh) mesh_q.delete();
      end else begin
        v = random_vertex(1'b0);
      end
      mesh_q.insert(mesh_q.size(), v);
      queue_vertex(v);
    end
  endtask

  task automatic flag_result(string what, result_t want, result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t %s: want idx %0d new %0b ovf %0b, got idx %0d new %0b ovf %0b",
               $time, what, want.vertex_index, want.is_new, want.table_overflow,
               got.vertex_index, got.is_new, got.table_overflow);
  endtask

  // driver: present the next vertex at the falling edge, hold it while stalled
  always @(negedge clk) begin
    if (rst) begin
      vtx_valid <= 1'b0;
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < idle_pct);
      if (sent_cnt == taken_cnt) begin
        if (vtx_pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          vtx <= vtx_pend_q.pop_front();
          vtx_valid <= 1'b1;
          sent_cnt++;
        end else begin
          vtx_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && vtx_valid && !vtx_stall) begin
      index_due_q.insert(index_due_q.size(), lookup_vertex(vtx));
      taken_cnt++;
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (index_due_q.size() == 0) begin
        flag_result("result with nothing pending", '0, res);
      end else begin
        want = index_due_q.pop_front();
        if (res.vertex_index !== want.vertex_index || res.is_new !== want.is_new ||
            res.table_overflow !== want.table_overflow)
          flag_result("result mismatch", want, res);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: near match, tolerance 655
    queue_vertex(flat_vertex(1'b1, coord_t'(0)));
    queue_vertex(flat_vertex(1'b0, coord_t'(0)));
    queue_vertex(put_comp(flat_vertex(1'b0, coord_t'(0)), 0, coord_t'(654)));
    queue_vertex(put_comp(flat_vertex(1'b0, coord_t'(0)), 7, coord_t'(-654)));
    queue_vertex(put_comp(flat_vertex(1'b0, coord_t'(0)), 3, coord_t'(655)));
    queue_vertex(flat_vertex(1'b0, C_MAX));
    queue_vertex(flat_vertex(1'b0, C_MIN));
    queue_vertex(flat_vertex(1'b0, C_MIN + coord_t'(654)));
    queue_vertex(flat_vertex(1'b0, 24'hAAAAAA));
    queue_vertex(flat_vertex(1'b0, 24'h555555));
    queue_vertex(flat_vertex(1'b1, 24'h555555));
    queue_vertex(flat_vertex(1'b0, coord_t'(0)));

    // unused register slots must leave the settings alone
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, '1);
    queue_vertex(put_comp(flat_vertex(1'b0, coord_t'(0)), 5, coord_t'(700)));

    write_reg(CFG_EXACT_MODE, 23'h7FFFF1);
    queue_vertex(flat_vertex(1'b0, coord_t'(0)));
    queue_vertex(put_comp(flat_vertex(1'b0, coord_t'(0)), 0, coord_t'(1)));
    queue_vertex(flat_vertex(1'b0, 24'h555555));

    // zero tolerance in near mode never matches
    write_reg(CFG_EXACT_MODE, 23'h7FFFFE);
    write_reg(CFG_MATCH_TOL, '0);
    queue_vertex(flat_vertex(1'b0, coord_t'(0)));
    queue_vertex(flat_vertex(1'b0, coord_t'(0)));

    write_reg(CFG_EXACT_MODE, '0);
    write_reg(CFG_MATCH_TOL, TOL_RESET);

    // random meshes under several settings; sender drains halfway through the first
    send_mesh_run(65, 700);
    wait_idle();
    send_mesh_run(65, 700);

    write_reg(CFG_EXACT_MODE, 23'h5A5A5B);
    idle_pct = 0;
    send_mesh_run(110, 2);
    wait_idle();
    idle_pct = 37;

    write_reg(CFG_EXACT_MODE, '0);
    write_reg(CFG_MATCH_TOL, TOL_BITS'($urandom_range(4000, 1)));
    send_mesh_run(110, int'(tol_cfg) + int'(tol_cfg) / 8 + 1);

    write_reg(CFG_MATCH_TOL, TOL_BITS'(1));
    send_mesh_run(110, 1);

    write_reg(CFG_MATCH_TOL, '1);
    send_mesh_run(105, 8388607);

    wait_idle();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (mismatch_cnt == 0 && index_due_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
